>>> sv/ttsw_pkg.sv
`timescale 1ns / 1ps
// shared types, constants, microcode table and helper functions of the terminal screen writer
package ttsw_pkg;

   localparam int COLUMNS_DEF = 40;
   localparam int ROWS_DEF    = 24;

   localparam int ACTION_W    = 2;
   localparam int CHAR_W      = 8;
   localparam int IDX_W       = 10;
   localparam int CODE_W      = 7;
   localparam int CURPOS_W    = 10;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic [CODE_W-1:0] CODE_LF     = 7'h0a;
   localparam logic [CODE_W-1:0] CODE_CR     = 7'h0d;
   localparam logic [CODE_W-1:0] CODE_RUBOUT = 7'h5f;
   localparam logic [CODE_W-1:0] CODE_CURSOR = 7'h01;
   localparam logic [CODE_W-1:0] CODE_SPACE  = 7'h20;
   localparam logic [CODE_W-1:0] CODE_VIS_HI = 7'h60;

   typedef logic [4:0] step_type;

   localparam step_type S_IDLE     = 5'd0;
   localparam step_type S_DISP     = 5'd1;
   localparam step_type S_CLR_INIT = 5'd2;
   localparam step_type S_CLR_LOOP = 5'd3;
   localparam step_type S_RD       = 5'd4;
   localparam step_type S_RD2      = 5'd5;
   localparam step_type S_NL       = 5'd6;
   localparam step_type S_RUB      = 5'd7;
   localparam step_type S_RUB2     = 5'd8;
   localparam step_type S_PUT      = 5'd9;
   localparam step_type S_CHK      = 5'd10;
   localparam step_type S_SC_INIT  = 5'd11;
   localparam step_type S_SC_RD    = 5'd12;
   localparam step_type S_SC_WR    = 5'd13;
   localparam step_type S_BT_INIT  = 5'd14;
   localparam step_type S_BT_RD    = 5'd15;
   localparam step_type S_BT_WR    = 5'd16;
   localparam step_type S_SC_END   = 5'd17;
   localparam step_type S_DONE     = 5'd18;
   localparam step_type S_BOOT     = 5'd19;

   typedef enum logic [1:0] {A_RDIDX, A_UPPER, A_IDX} asel_type;
   typedef enum logic [1:0] {W_NONE, W_ALWAYS, W_MOVED, W_VISIBLE} wcond_type;
   typedef enum logic [1:0] {WA_IDX, WA_UPPER, WA_CURSOR} waddr_type;
   typedef enum logic [1:0] {WD_ZERO, WD_CHAR, WD_B} wdata_type;
   typedef enum logic [2:0] {I_HOLD, I_ZERO, I_COLS, I_BOTTOM, I_INC} idxop_type;
   typedef enum logic [2:0] {K_HOLD, K_ZERO, K_NEWLINE, K_BACK, K_ADV, K_UP} curop_type;
   typedef enum logic [1:0] {Q_HOLD, Q_ZERO, Q_READ} codeop_type;
   typedef enum logic [2:0] {C_ALWAYS, C_NOREQ, C_LAST, C_CUR_IN, C_OUTBUSY,
                             C_DISPATCH} cond_type;

   typedef struct packed {
      logic       ready;
      logic       emit;
      asel_type   asel;
      wcond_type  wcond;
      waddr_type  waddr;
      wdata_type  wdata;
      idxop_type  idxop;
      curop_type  curop;
      codeop_type codeop;
      cond_type   cond;
      step_type   tgt_t;
      step_type   tgt_f;
   } ctrl_type;

   typedef struct packed {
      logic                last;
      logic                cur_in;
      logic                out_busy;
      logic [ACTION_W-1:0] action;
      logic [CODE_W-1:0]   code;
   } stat_type;

   localparam ctrl_type CTRL_NOP = '{
      ready: 1'b0, emit: 1'b0, asel: A_IDX, wcond: W_NONE, waddr: WA_IDX,
      wdata: WD_ZERO, idxop: I_HOLD, curop: K_HOLD, codeop: Q_HOLD,
      cond: C_ALWAYS, tgt_t: S_IDLE, tgt_f: S_IDLE};

   // 0, 2..32 and above 96
   function automatic logic blank_like(input logic [CODE_W-1:0] v);
      blank_like = (v == '0) || (v > CODE_CURSOR && v <= CODE_SPACE) || (v > CODE_VIS_HI);
   endfunction

   function automatic step_type dispatch_step(input logic [ACTION_W-1:0] act,
                                              input logic [CODE_W-1:0] c);
      step_type s;
      s = S_DONE;
      if (act == ACT_WRITE) begin
         if (c == CODE_LF || c == CODE_CR) begin
            s = S_NL;
         end else if (c == CODE_RUBOUT) begin
            s = S_RUB;
         end else begin
            s = S_PUT;
         end
      end else if (act == ACT_CLEAR) begin
         s = S_CLR_INIT;
      end else if (act == ACT_READ) begin
         s = S_RD;
      end
      return s;
   endfunction

   function automatic ctrl_type ucode_rom(input step_type s);
      ctrl_type w;
      w = CTRL_NOP;
      unique case (s)
         S_IDLE: begin
            w.ready = 1'b1; w.cond = C_NOREQ; w.tgt_t = S_IDLE; w.tgt_f = S_DISP;
         end
         S_DISP: begin
            w.codeop = Q_ZERO; w.cond = C_DISPATCH;
         end
         S_CLR_INIT: begin
            w.idxop = I_ZERO; w.curop = K_ZERO; w.tgt_t = S_CLR_LOOP;
         end
         S_CLR_LOOP: begin
            w.wcond = W_ALWAYS; w.waddr = WA_IDX; w.wdata = WD_ZERO; w.idxop = I_INC;
            w.cond = C_LAST; w.tgt_t = S_DONE; w.tgt_f = S_CLR_LOOP;
         end
         S_RD: begin
            w.asel = A_RDIDX; w.tgt_t = S_RD2;
         end
         S_RD2: begin
            w.codeop = Q_READ; w.tgt_t = S_DONE;
         end
         S_NL: begin
            w.curop = K_NEWLINE; w.tgt_t = S_CHK;
         end
         S_RUB: begin
            w.curop = K_BACK; w.tgt_t = S_RUB2;
         end
         S_RUB2: begin
            w.wcond = W_ALWAYS; w.waddr = WA_CURSOR; w.wdata = WD_ZERO; w.tgt_t = S_CHK;
         end
         S_PUT: begin
            w.wcond = W_ALWAYS; w.waddr = WA_CURSOR; w.wdata = WD_CHAR;
            w.curop = K_ADV; w.tgt_t = S_CHK;
         end
         S_CHK: begin
            w.cond = C_CUR_IN; w.tgt_t = S_DONE; w.tgt_f = S_SC_INIT;
         end
         S_SC_INIT: begin
            w.idxop = I_COLS; w.tgt_t = S_SC_RD;
         end
         S_SC_RD: begin
            w.asel = A_UPPER; w.tgt_t = S_SC_WR;
         end
         S_SC_WR: begin
            w.wcond = W_MOVED; w.waddr = WA_UPPER; w.wdata = WD_B; w.idxop = I_INC;
            w.cond = C_LAST; w.tgt_t = S_BT_INIT; w.tgt_f = S_SC_RD;
         end
         S_BT_INIT: begin
            w.idxop = I_BOTTOM; w.tgt_t = S_BT_RD;
         end
         S_BT_RD: begin
            w.asel = A_IDX; w.tgt_t = S_BT_WR;
         end
         S_BT_WR: begin
            w.wcond = W_VISIBLE; w.waddr = WA_IDX; w.wdata = WD_ZERO; w.idxop = I_INC;
            w.cond = C_LAST; w.tgt_t = S_SC_END; w.tgt_f = S_BT_RD;
         end
         S_SC_END: begin
            w.curop = K_UP; w.tgt_t = S_DONE;
         end
         S_DONE: begin
            w.emit = 1'b1; w.cond = C_OUTBUSY; w.tgt_t = S_DONE; w.tgt_f = S_IDLE;
         end
         S_BOOT: begin
            w.wcond = W_ALWAYS; w.waddr = WA_IDX; w.wdata = WD_ZERO; w.idxop = I_INC;
            w.cond = C_LAST; w.tgt_t = S_IDLE; w.tgt_f = S_BOOT;
         end
         default: begin
            w.tgt_t = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> sv/ttsw_ram.sv
`timescale 1ns / 1ps
// generic ram with one write port and two registered read ports
module ttsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data <= mem_ff[rd_a_addr];
      rd_b_data <= mem_ff[rd_b_addr];
   end

endmodule

>>> sv/ttsw_seq.sv
`timescale 1ns / 1ps
// microcode sequencer: step counter, control store lookup and branch logic
module ttsw_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  ttsw_pkg::stat_type  stat,
   output ttsw_pkg::ctrl_type  ctrl
);
   import ttsw_pkg::*;

   step_type pc_ff;
   step_type pc_in;

   assign ctrl = ucode_rom(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         C_ALWAYS:   pc_in = ctrl.tgt_t;
         C_NOREQ:    pc_in = req_tvalid ? ctrl.tgt_f : ctrl.tgt_t;
         C_LAST:     pc_in = stat.last ? ctrl.tgt_t : ctrl.tgt_f;
         C_CUR_IN:   pc_in = stat.cur_in ? ctrl.tgt_t : ctrl.tgt_f;
         C_OUTBUSY:  pc_in = stat.out_busy ? ctrl.tgt_t : ctrl.tgt_f;
         C_DISPATCH: pc_in = dispatch_step(stat.action, stat.code);
         default:    pc_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_BOOT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_IDLE && req_tvalid) |=> (pc_ff == S_DISP))
      else $error("accepted request not dispatched");

endmodule

>>> sv/ttsw_dpath.sv
`timescale 1ns / 1ps
// datapath: screen ram, cell counter, cursor, request latch and result register
module ttsw_dpath #(
   parameter int COLUMNS = ttsw_pkg::COLUMNS_DEF,
   parameter int ROWS    = ttsw_pkg::ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ttsw_pkg::ctrl_type                  ctrl,
   output ttsw_pkg::stat_type                  stat,
   input  logic                                req_tvalid,
   input  logic [ttsw_pkg::ACTION_W-1:0]       req_tuser,
   input  logic [ttsw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ttsw_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import ttsw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CUR_W  = $clog2(CELLS + COLUMNS);
   localparam int CMP_W  = CUR_W + IDX_W;

   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [CUR_W-1:0]    cursor_ff, cursor_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ACTION_W-1:0] act_ff;
   logic [CODE_W-1:0]   chr_ff;
   logic [IDX_W-1:0]    rdidx_ff;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [CODE_W-1:0]   rsp_code_ff;
   logic [CURPOS_W-1:0] rsp_cur_ff;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [CODE_W-1:0]   wr_data;
   logic [ADDR_W-1:0]   a_addr;
   logic [CODE_W-1:0]   a_data;
   logic [CODE_W-1:0]   b_data;

   logic [ADDR_W-1:0]   upper;
   logic [CMP_W-1:0]    rd_wide;
   logic [CMP_W-1:0]    cur_wide;
   logic                rd_in_range;
   logic                rd_hit;
   logic                col_last;
   logic                out_busy;
   logic                take;

   assign upper       = idx_ff - ADDR_W'(COLUMNS);
   assign rd_wide     = {CUR_W'(0), rdidx_ff};
   assign cur_wide    = {IDX_W'(0), cursor_ff};
   assign rd_in_range = rd_wide < CMP_W'(CELLS);
   assign rd_hit      = rd_wide == cur_wide;
   assign col_last    = col_ff == COL_W'(COLUMNS - 1);
   assign out_busy    = rsp_valid_ff && !rsp_tready;
   assign take        = ctrl.ready && req_tvalid;

   assign stat.last     = idx_ff == ADDR_W'(CELLS - 1);
   assign stat.cur_in   = cursor_ff < CUR_W'(CELLS);
   assign stat.out_busy = out_busy;
   assign stat.action   = act_ff;
   assign stat.code     = chr_ff;

   ttsw_ram #(
      .WIDTH (CODE_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (a_addr),
      .rd_a_data (a_data),
      .rd_b_addr (idx_ff),
      .rd_b_data (b_data)
   );

   always_comb begin
      unique case (ctrl.wcond)
         W_NONE:    wr_en = 1'b0;
         W_ALWAYS:  wr_en = 1'b1;
         W_MOVED:   wr_en = !(blank_like(a_data) && blank_like(b_data));
         W_VISIBLE: wr_en = !blank_like(a_data);
         default:   wr_en = 1'b0;
      endcase
      unique case (ctrl.waddr)
         WA_IDX:    wr_addr = idx_ff;
         WA_UPPER:  wr_addr = upper;
         WA_CURSOR: wr_addr = cursor_ff[ADDR_W-1:0];
         default:   wr_addr = idx_ff;
      endcase
      unique case (ctrl.wdata)
         WD_ZERO: wr_data = '0;
         WD_CHAR: wr_data = chr_ff;
         WD_B:    wr_data = b_data;
         default: wr_data = '0;
      endcase
      unique case (ctrl.asel)
         A_RDIDX: a_addr = rd_wide[ADDR_W-1:0];
         A_UPPER: a_addr = upper;
         A_IDX:   a_addr = idx_ff;
         default: a_addr = idx_ff;
      endcase
   end

   always_comb begin
      unique case (ctrl.idxop)
         I_HOLD:   idx_in = idx_ff;
         I_ZERO:   idx_in = '0;
         I_COLS:   idx_in = ADDR_W'(COLUMNS);
         I_BOTTOM: idx_in = ADDR_W'(CELLS - COLUMNS);
         I_INC:    idx_in = idx_ff + 1'b1;
         default:  idx_in = idx_ff;
      endcase
   end

   always_comb begin
      cursor_in = cursor_ff;
      col_in    = col_ff;
      unique case (ctrl.curop)
         K_HOLD: begin
         end
         K_ZERO: begin
            cursor_in = '0;
            col_in    = '0;
         end
         K_NEWLINE: begin
            cursor_in = cursor_ff + CUR_W'(COLUMNS) - CUR_W'(col_ff);
            col_in    = '0;
         end
         K_BACK: begin
            if (cursor_ff != '0) begin
               cursor_in = cursor_ff - 1'b1;
               col_in    = (col_ff == '0) ? COL_W'(COLUMNS - 1) : col_ff - 1'b1;
            end
         end
         K_ADV: begin
            cursor_in = cursor_ff + 1'b1;
            col_in    = col_last ? '0 : col_ff + 1'b1;
         end
         K_UP: begin
            cursor_in = cursor_ff - CUR_W'(COLUMNS);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (ctrl.codeop)
         Q_HOLD:  code_in = code_ff;
         Q_ZERO:  code_in = '0;
         Q_READ:  code_in = !rd_in_range ? '0 : (rd_hit ? CODE_CURSOR : a_data);
         default: code_in = code_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit && !out_busy) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         cursor_ff    <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         act_ff   <= req_tuser;
         chr_ff   <= req_tdata[CODE_W-1:0];
         rdidx_ff <= req_tdata[CHAR_W +: IDX_W];
      end
      code_ff <= code_in;
      if (ctrl.emit && !out_busy) begin
         rsp_code_ff <= code_ff;
         rsp_cur_ff  <= cur_wide[CURPOS_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - CURPOS_W - CODE_W)'(0), rsp_cur_ff, rsp_code_ff};

   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      ctrl.ready |-> (cursor_ff < CUR_W'(CELLS)))
      else $error("cursor beyond screen while idle");

   a_write_in_screen: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} < (ADDR_W + 1)'(CELLS)))
      else $error("screen write out of range");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit && !out_busy) |=> (rsp_tvalid && rsp_code_ff == $past(code_ff)))
      else $error("result not loaded on emit");

endmodule

>>> sv/text_terminal_screen_writer_unit.sv
`timescale 1ns / 1ps
// top level of the text terminal screen writer
//
//  channel | dir | tvalid/tready          | payload
//  req     | in  | req_tvalid/req_tready  | tuser action, tdata character, cell_index
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata cell_code, cursor_position
//
// a clear walks every one of the cells (cells = columns * rows)
// a write that reaches the screen end adds a scroll, carried out by the single ram write port
// walking every cell under the microcode loop
// after reset a clearing pass over every cell runs before req_tready rises
// a stalled rsp holds the sequencer in its final step; the next request is taken
// while a finished result waits
module text_terminal_screen_writer_unit #(
   parameter int COLUMNS = ttsw_pkg::COLUMNS_DEF,
   parameter int ROWS    = ttsw_pkg::ROWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ttsw_pkg::ACTION_W-1:0]    req_tuser,   // action
   input  logic [ttsw_pkg::REQ_TDATA_W-1:0] req_tdata,   // character[7:0], cell_index[17:8]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ttsw_pkg::RSP_TDATA_W-1:0] rsp_tdata    // cell_code[6:0], cursor_position[16:7]
);
   import ttsw_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   assign req_tready = ctrl.ready;

   ttsw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   ttsw_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
